>>> rtl/ictf_pkg.sv
// Package for the complementary tilt filter: widths, register indexes, atan table.
// No dependencies.
`timescale 1ns / 1ps
package ictf_pkg;
  localparam int AngW = 24;
  localparam int CordicSteps = 16;
  localparam int TabLen = 24;
  localparam int CordW = 40;
  localparam int ZW = 32;
  localparam int SqW = 42;
  localparam int RootW = 21;
  localparam int StepW = $clog2(TabLen + 1);

  localparam logic [1:0] REG_GYRO_WEIGHT = 2'd0;
  localparam logic [1:0] REG_ACCEL_WEIGHT = 2'd1;
  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd2;

  localparam logic signed [AngW-1:0] AngMax = 24'sh7FFFFF;
  localparam logic signed [AngW-1:0] AngMin = -24'sh800000;

  typedef struct packed {
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } imu_sample_t;

  typedef struct packed {
    logic signed [AngW-1:0] pitch_angle;
    logic signed [AngW-1:0] roll_angle;
    logic accel_applied;
  } tilt_result_t;

  typedef struct packed {
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic gate_ok;
  } tilt_job_t;

  function automatic logic [ZW-1:0] atan_entry(input logic [StepW-1:0] i);
    case (i)
      5'd0: atan_entry = 32'd2949120;
      5'd1: atan_entry = 32'd1740967;
      5'd2: atan_entry = 32'd919879;
      5'd3: atan_entry = 32'd466945;
      5'd4: atan_entry = 32'd234379;
      5'd5: atan_entry = 32'd117304;
      5'd6: atan_entry = 32'd58666;
      5'd7: atan_entry = 32'd29335;
      5'd8: atan_entry = 32'd14668;
      5'd9: atan_entry = 32'd7334;
      5'd10: atan_entry = 32'd3667;
      5'd11: atan_entry = 32'd1833;
      5'd12: atan_entry = 32'd917;
      5'd13: atan_entry = 32'd458;
      5'd14: atan_entry = 32'd229;
      5'd15: atan_entry = 32'd115;
      5'd16: atan_entry = 32'd57;
      5'd17: atan_entry = 32'd29;
      5'd18: atan_entry = 32'd14;
      5'd19: atan_entry = 32'd7;
      5'd20: atan_entry = 32'd4;
      5'd21: atan_entry = 32'd2;
      5'd22: atan_entry = 32'd1;
      default: atan_entry = '0;
    endcase
  endfunction

  function automatic logic signed [AngW-1:0] sat24(input logic signed [47:0] v);
    if (v > 48'(AngMax)) sat24 = AngMax;
    else if (v < 48'(AngMin)) sat24 = AngMin;
    else sat24 = v[AngW-1:0];
  endfunction
endpackage

>>> rtl/ictf_stream_if.sv
// Valid/ready channel interface carrying one payload of type T.
// Uses ictf_pkg types at instantiation.
`timescale 1ns / 1ps
interface ictf_stream_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/ictf_front.sv
// Front end: accepts IMU samples, computes the accel gate, pushes a job queue.
// Depends on ictf_pkg.
`timescale 1ns / 1ps
module ictf_front import ictf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  imu_sample_t in_data,
  input  logic        in_valid,
  output logic        in_ready,
  output tilt_job_t   job,
  output logic        job_valid,
  input  logic        job_ready
);
  tilt_job_t q [2];
  logic [1:0] count;
  logic rd_ptr, wr_ptr;
  logic push, pop;
  logic [16:0] ax_abs, ay_abs, az_abs;
  logic [17:0] mag;
  tilt_job_t incoming;

  always_comb begin
    ax_abs = in_data.accel_x[15] ? 17'(-17'(signed'(in_data.accel_x))) : 17'(in_data.accel_x);
    ay_abs = in_data.accel_y[15] ? 17'(-17'(signed'(in_data.accel_y))) : 17'(in_data.accel_y);
    az_abs = in_data.accel_z[15] ? 17'(-17'(signed'(in_data.accel_z))) : 17'(in_data.accel_z);
    mag = 18'(ax_abs) + 18'(ay_abs) + 18'(az_abs);
    incoming.rate_x = in_data.rate_x;
    incoming.rate_y = in_data.rate_y;
    incoming.accel_x = in_data.accel_x;
    incoming.accel_y = in_data.accel_y;
    incoming.accel_z = in_data.accel_z;
    incoming.gate_ok = (mag > 18'd2048) && (mag < 18'd8192);
  end

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign job_valid = (count != 2'd0);
  assign pop = job_valid && job_ready;
  assign job = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= incoming;
    if (rst) begin
      count <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("job queue overflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("job queue count bad");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1) else $error("count push");
endmodule

>>> rtl/ictf_back.sv
// Back end: gyro integration, sqrt and CORDIC atan per axis, blend, output register.
// Depends on ictf_pkg.
`timescale 1ns / 1ps
module ictf_back import ictf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  tilt_job_t    job,
  input  logic         job_valid,
  output logic         job_ready,
  input  logic [15:0]  gyro_weight,
  input  logic [15:0]  accel_weight,
  input  logic [15:0]  sample_period,
  output tilt_result_t res,
  output logic         res_valid,
  input  logic         res_ready
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_INTEG = 8'b00000010,
    S_SQRT  = 8'b00000100,
    S_CORD  = 8'b00001000,
    S_BLEND = 8'b00010000,
    S_MULT  = 8'b00100000,
    S_SUM   = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t state;
  tilt_job_t cur;
  logic axis;  // 0: pitch, 1: roll
  logic signed [AngW-1:0] pitch, roll;
  logic signed [32:0] dprod_r, dprod_p;
  logic [SqW-1:0] sq_v, sq_bit;
  logic [SqW-1:0] sq_r;
  logic signed [CordW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic [StepW-1:0] step;
  logic signed [AngW-1:0] tilt_ang;
  logic signed [47:0] prod_a, prod_b;
  logic [SqW-1:0] sq_pitch, sq_roll;
  logic signed [31:0] xx_sq, yy_sq, zz_sq;
  logic signed [15:0] num_v, c_v;
  logic signed [CordW-1:0] xs, ys;
  logic signed [ZW-1:0] zr;
  logic signed [AngW-1:0] ang_sel;
  logic signed [47:0] blend_sum;
  logic cord_last;
  logic applied;

  always_comb begin
    num_v = axis ? cur.accel_y : cur.accel_x;
    c_v = cur.accel_z;
    xx_sq = cur.accel_x * cur.accel_x;
    yy_sq = cur.accel_y * cur.accel_y;
    zz_sq = c_v * c_v;
    sq_pitch = (SqW'(unsigned'(yy_sq)) + SqW'(unsigned'(zz_sq))) << 8;
    sq_roll = (SqW'(unsigned'(xx_sq)) + SqW'(unsigned'(zz_sq))) << 8;
    xs = cx >>> step;
    ys = cy >>> step;
    zr = (cz + 32'sd128) >>> 8;
    ang_sel = axis ? roll : pitch;
    blend_sum = prod_a + prod_b + 48'sd32768;
    cord_last = (step == StepW'(CordicSteps - 1)) || (step == StepW'(TabLen - 1));
  end

  assign job_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pitch <= '0;
      roll <= '0;
      axis <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (job_valid) begin
          cur <= job;
          dprod_r <= $signed(33'(job.rate_x)) * $signed({1'b0, sample_period});
          dprod_p <= $signed(33'(job.rate_y)) * $signed({1'b0, sample_period});
          state <= S_INTEG;
        end
        S_INTEG: begin
          roll <= sat24(48'(roll) + 48'((dprod_r + 33'sd2048) >>> 12));
          pitch <= sat24(48'(pitch) - 48'((dprod_p + 33'sd2048) >>> 12));
          axis <= 1'b0;
          if (cur.gate_ok) begin
            sq_v <= sq_pitch;
            sq_r <= '0;
            sq_bit <= SqW'(1) << (SqW - 2);
            state <= S_SQRT;
          end else begin
            applied <= 1'b0;
            state <= S_DONE;
          end
        end
        S_SQRT: begin
          // restoring square root, one result bit per cycle
          if (sq_bit == '0) begin
            cx <= CordW'(sq_r);
            cy <= CordW'(num_v) <<< 4;
            cz <= '0;
            step <= '0;
            state <= S_CORD;
          end else begin
            if (sq_v >= sq_r + sq_bit) begin
              sq_v <= sq_v - (sq_r + sq_bit);
              sq_r <= (sq_r >> 1) + sq_bit;
            end else begin
              sq_r <= sq_r >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        S_CORD: begin
          if (cy >= 0) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + $signed(atan_entry(step));
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - $signed(atan_entry(step));
          end
          if (cord_last) state <= S_BLEND;
          step <= step + 1'b1;
        end
        S_BLEND: begin
          tilt_ang <= zr[AngW-1:0];
          state <= S_MULT;
        end
        S_MULT: begin
          prod_a <= 48'(ang_sel) * $signed({1'b0, gyro_weight});
          prod_b <= 48'(tilt_ang) * $signed({1'b0, accel_weight});
          state <= S_SUM;
        end
        S_SUM: begin
          if (axis) roll <= sat24(blend_sum >>> 16);
          else pitch <= sat24(blend_sum >>> 16);
          if (axis) begin
            applied <= 1'b1;
            state <= S_DONE;
          end else begin
            axis <= 1'b1;
            sq_v <= sq_roll;
            sq_r <= '0;
            sq_bit <= SqW'(1) << (SqW - 2);
            state <= S_SQRT;
          end
        end
        S_DONE: if (res_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.pitch_angle = pitch;
  assign res.roll_angle = roll;
  assign res.accel_applied = applied;

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    job_ready |-> !res_valid) else $error("accept while result pending");
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(pitch) && $stable(roll))
    else $error("result changed while stalled");
  a_cord_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_CORD |-> step < StepW'(TabLen)) else $error("cordic step overrun");
endmodule

>>> rtl/imu_complementary_tilt_filter_top.sv
// Complementary pitch/roll filter. Each accepted IMU sample gives one result
// transaction. A sample outside the accel gate only has its gyro rates
// integrated; one inside also runs the one-bit-per-cycle square root and the
// CORDIC iteration in the back end, which are reused for pitch and then roll.
// The back end takes no new job until its result is accepted, so output
// stalls hold it. A two-entry queue sits between front and back.
// Depends on ictf_pkg, ictf_stream_if, ictf_front, ictf_back.
`timescale 1ns / 1ps
module imu_complementary_tilt_filter_top import ictf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ictf_stream_if.sink   in_ch,
  ictf_stream_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic [15:0] gyro_weight, accel_weight, sample_period;
  tilt_job_t job;
  logic job_valid, job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_weight <= 16'd64881;
      accel_weight <= 16'd655;
      sample_period <= 16'd1966;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GYRO_WEIGHT: gyro_weight <= cfg_data;
        REG_ACCEL_WEIGHT: accel_weight <= cfg_data;
        REG_SAMPLE_PERIOD: sample_period <= cfg_data;
        default: ;
      endcase
    end
  end

  ictf_front u_front (
    .clk, .rst,
    .in_data(in_ch.payload), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .job, .job_valid, .job_ready
  );

  ictf_back u_back (
    .clk, .rst, .job, .job_valid, .job_ready,
    .gyro_weight, .accel_weight, .sample_period,
    .res(out_ch.payload), .res_valid(out_ch.valid), .res_ready(out_ch.ready)
  );
endmodule
